### rtl/iira_pkg.sv
// ----------------------------------------------------------------------------
// iira_pkg
// Shared types, codes and the control store of the indexed insert/remove list.
// ----------------------------------------------------------------------------
package iira_pkg;

	// Capacity of the list and the widths that follow from it
	localparam int DEPTH  = 256;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	// Width at which pointer, count and position are compared
	localparam int CMP_W  = ((CNT_W > 8) ? CNT_W : 8) + 1;

	// Operation codes
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Input and result items
	typedef struct packed {
		logic [1:0]        action;
		logic [7:0]        position;
		logic signed [31:0] value_in;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic [1:0]         status;
		logic [8:0]         count;
	} out_item_t;

	// Step addresses of the control program
	typedef enum logic [3:0] {
		U_IDLE      = 4'd0,
		U_INS_CHK   = 4'd1,
		U_INS_SHIFT = 4'd2,
		U_INS_PUT   = 4'd3,
		U_RD_ADDR   = 4'd4,
		U_RD_TAKE   = 4'd5,
		U_RM_CHK    = 4'd6,
		U_RM_SHIFT  = 4'd7,
		U_RM_END    = 4'd8,
		U_EM_OK0    = 4'd9,
		U_EM_DATA   = 4'd10,
		U_EM_RANGE  = 4'd11,
		U_EM_FULL   = 4'd12
	} step_t;

	// Branch conditions
	typedef enum logic [2:0] {
		C_TRUE,
		C_PTR_EQ_POS,
		C_PTR_M1_EQ_POS,
		C_IS_READ,
		C_PTR_P1_EQ_CNT,
		C_PTR_P2_EQ_CNT,
		C_OUT_BUSY
	} cond_t;

	// Memory read address source
	typedef enum logic [2:0] {
		A_PTR_M2,
		A_PTR_M1,
		A_PTR,
		A_PTR_P1,
		A_PTR_P2
	} addr_sel_t;

	// Memory write source
	typedef enum logic [1:0] {
		W_NONE,
		W_SHIFT,
		W_PUT
	} wr_sel_t;

	// Counter updates for the pointer and the entry count
	typedef enum logic [1:0] {
		K_HOLD,
		K_INC,
		K_DEC
	} cnt_op_t;

	// One control word
	typedef struct packed {
		logic      dispatch;
		cond_t     cond;
		step_t     tgt;
		step_t     nxt;
		addr_sel_t rd_sel;
		wr_sel_t   wr_sel;
		cnt_op_t   ptr_op;
		cnt_op_t   cnt_op;
		logic      take;
		logic      emit;
		logic      val_data;
		logic [1:0] status;
	} ctrl_t;

	// Control store
	function automatic ctrl_t ucode(step_t step);
		ctrl_t w;
		w = '{dispatch: 1'b0, cond: C_TRUE, tgt: U_IDLE, nxt: U_IDLE,
			rd_sel: A_PTR, wr_sel: W_NONE, ptr_op: K_HOLD, cnt_op: K_HOLD,
			take: 1'b0, emit: 1'b0, val_data: 1'b0, status: ST_OK};
		case (step)
			U_IDLE: begin
				w.dispatch = 1'b1;
			end
			// Nothing to move when inserting at the end
			U_INS_CHK: begin
				w.cond   = C_PTR_EQ_POS;
				w.tgt    = U_INS_PUT;
				w.nxt    = U_INS_SHIFT;
				w.rd_sel = A_PTR_M1;
			end
			// Move one entry up, fetch the one below it
			U_INS_SHIFT: begin
				w.cond   = C_PTR_M1_EQ_POS;
				w.tgt    = U_INS_PUT;
				w.nxt    = U_INS_SHIFT;
				w.rd_sel = A_PTR_M2;
				w.wr_sel = W_SHIFT;
				w.ptr_op = K_DEC;
			end
			U_INS_PUT: begin
				w.tgt    = U_EM_OK0;
				w.wr_sel = W_PUT;
				w.cnt_op = K_INC;
			end
			U_RD_ADDR: begin
				w.tgt    = U_RD_TAKE;
				w.rd_sel = A_PTR;
			end
			U_RD_TAKE: begin
				w.cond = C_IS_READ;
				w.tgt  = U_EM_DATA;
				w.nxt  = U_RM_CHK;
				w.take = 1'b1;
			end
			// Removing the last entry moves nothing
			U_RM_CHK: begin
				w.cond   = C_PTR_P1_EQ_CNT;
				w.tgt    = U_RM_END;
				w.nxt    = U_RM_SHIFT;
				w.rd_sel = A_PTR_P1;
			end
			// Move one entry down, fetch the one above the next
			U_RM_SHIFT: begin
				w.cond   = C_PTR_P2_EQ_CNT;
				w.tgt    = U_RM_END;
				w.nxt    = U_RM_SHIFT;
				w.rd_sel = A_PTR_P2;
				w.wr_sel = W_SHIFT;
				w.ptr_op = K_INC;
			end
			U_RM_END: begin
				w.tgt    = U_EM_DATA;
				w.cnt_op = K_DEC;
			end
			U_EM_OK0: begin
				w.cond = C_OUT_BUSY;
				w.tgt  = U_EM_OK0;
				w.emit = 1'b1;
			end
			U_EM_DATA: begin
				w.cond     = C_OUT_BUSY;
				w.tgt      = U_EM_DATA;
				w.emit     = 1'b1;
				w.val_data = 1'b1;
			end
			U_EM_RANGE: begin
				w.cond   = C_OUT_BUSY;
				w.tgt    = U_EM_RANGE;
				w.emit   = 1'b1;
				w.status = ST_RANGE;
			end
			U_EM_FULL: begin
				w.cond   = C_OUT_BUSY;
				w.tgt    = U_EM_FULL;
				w.emit   = 1'b1;
				w.status = ST_FULL;
			end
			default: begin
				w.tgt = U_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

### rtl/iira_ram.sv
// ----------------------------------------------------------------------------
// iira_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module iira_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write when wr_en is set; read every cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### rtl/indexed_insert_remove_array.sv
// ----------------------------------------------------------------------------
// indexed_insert_remove_array
// Ordered list of signed words with insert, remove and read at a position.
// ----------------------------------------------------------------------------
// Usage:
//   in_item  (valid/ready): action, position, value_in. One item at a time.
//   out_item (valid/ready): value_out, status, count. One result per item.
//   The list lives in a single RAM; a small control program steps through it.
//   Insert and remove shift the entries between the position and the end
//   of the list, so their time per item grows with that distance; read
//   and any error move nothing. The shift loop moves one entry per cycle
//   through the RAM's single write port.
//   The result shows up on out_item in the same cycle as the next item can
//   be taken. A result waiting in the output register does not block the
//   next item; only its own result waits until the earlier one is taken.
//   Reset empties the list at once (count to zero); RAM contents are left.
// ----------------------------------------------------------------------------
module indexed_insert_remove_array (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  iira_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output iira_pkg::out_item_t out_item
);

	iira_pkg::step_t     upc_q;
	iira_pkg::step_t     upc_d;
	iira_pkg::step_t     disp;
	iira_pkg::ctrl_t     cw;
	logic [iira_pkg::CNT_W-1:0]  ptr_q;
	logic [iira_pkg::CNT_W-1:0]  cnt_q;
	logic [1:0]                  act_q;
	logic [7:0]                  pos_q;
	logic [iira_pkg::WORD_W-1:0] val_q;
	logic [iira_pkg::WORD_W-1:0] data_q;
	logic                        out_valid_q;
	iira_pkg::out_item_t         out_q;
	logic                        accept;
	logic                        cond_hit;
	logic                        out_busy;
	logic [iira_pkg::CMP_W-1:0]  ptr_w;
	logic [iira_pkg::CMP_W-1:0]  cnt_w;
	logic [iira_pkg::CMP_W-1:0]  pos_w;
	logic [iira_pkg::CMP_W-1:0]  in_pos_w;
	logic [iira_pkg::CNT_W-1:0]  rd_ptr;
	logic                        wr_en;
	logic [iira_pkg::ADDR_W-1:0] wr_addr;
	logic [iira_pkg::WORD_W-1:0] wr_data;
	logic [iira_pkg::ADDR_W-1:0] rd_addr;
	logic [iira_pkg::WORD_W-1:0] rd_data;

	// Fetch the current control word
	always_comb begin
		cw = iira_pkg::ucode(upc_q);
	end

	assign in_ready  = cw.dispatch;
	assign accept    = in_valid && cw.dispatch;
	assign out_busy  = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Compare operands at a common width
	assign ptr_w    = iira_pkg::CMP_W'(ptr_q);
	assign cnt_w    = iira_pkg::CMP_W'(cnt_q);
	assign pos_w    = iira_pkg::CMP_W'(pos_q);
	assign in_pos_w = iira_pkg::CMP_W'(in_item.position);

	// Pick the first step from the operation, the position check and, for insert, the full check
	always_comb begin
		disp = iira_pkg::U_EM_RANGE;
		case (in_item.action)
			iira_pkg::ACT_INSERT: begin
				if (in_pos_w > cnt_w) begin
					disp = iira_pkg::U_EM_RANGE;
				end else if (cnt_w == iira_pkg::CMP_W'(iira_pkg::DEPTH)) begin
					disp = iira_pkg::U_EM_FULL;
				end else begin
					disp = iira_pkg::U_INS_CHK;
				end
			end
			iira_pkg::ACT_REMOVE, iira_pkg::ACT_READ: begin
				if (in_pos_w >= cnt_w) begin
					disp = iira_pkg::U_EM_RANGE;
				end else begin
					disp = iira_pkg::U_RD_ADDR;
				end
			end
			default: begin
				disp = iira_pkg::U_EM_RANGE;
			end
		endcase
	end

	// Evaluate the branch condition
	always_comb begin
		case (cw.cond)
			iira_pkg::C_TRUE:          cond_hit = 1'b1;
			iira_pkg::C_PTR_EQ_POS:    cond_hit = (ptr_w == pos_w);
			iira_pkg::C_PTR_M1_EQ_POS:
				cond_hit = (ptr_w - iira_pkg::CMP_W'(1) == pos_w);
			iira_pkg::C_IS_READ:       cond_hit = (act_q == iira_pkg::ACT_READ);
			iira_pkg::C_PTR_P1_EQ_CNT:
				cond_hit = (ptr_w + iira_pkg::CMP_W'(1) == cnt_w);
			iira_pkg::C_PTR_P2_EQ_CNT:
				cond_hit = (ptr_w + iira_pkg::CMP_W'(2) == cnt_w);
			iira_pkg::C_OUT_BUSY:      cond_hit = out_busy;
			default:                   cond_hit = 1'b0;
		endcase
	end

	// Next step
	always_comb begin
		if (cw.dispatch) begin
			upc_d = accept ? disp : iira_pkg::U_IDLE;
		end else if (cond_hit) begin
			upc_d = cw.tgt;
		end else begin
			upc_d = cw.nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= iira_pkg::U_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

	// Memory read address
	always_comb begin
		case (cw.rd_sel)
			iira_pkg::A_PTR_M2: rd_ptr = ptr_q - iira_pkg::CNT_W'(2);
			iira_pkg::A_PTR_M1: rd_ptr = ptr_q - iira_pkg::CNT_W'(1);
			iira_pkg::A_PTR_P1: rd_ptr = ptr_q + iira_pkg::CNT_W'(1);
			iira_pkg::A_PTR_P2: rd_ptr = ptr_q + iira_pkg::CNT_W'(2);
			default:            rd_ptr = ptr_q;
		endcase
	end
	assign rd_addr = rd_ptr[iira_pkg::ADDR_W-1:0];

	// Memory write: shift moves fetched data to the pointer, put stores the word
	always_comb begin
		case (cw.wr_sel)
			iira_pkg::W_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q[iira_pkg::ADDR_W-1:0];
				wr_data = rd_data;
			end
			iira_pkg::W_PUT: begin
				wr_en   = 1'b1;
				wr_addr = iira_pkg::ADDR_W'(pos_q);
				wr_data = val_q;
			end
			default: begin
				wr_en   = 1'b0;
				wr_addr = ptr_q[iira_pkg::ADDR_W-1:0];
				wr_data = rd_data;
			end
		endcase
	end

	iira_ram #(
		.WIDTH(iira_pkg::WORD_W),
		.DEPTH(iira_pkg::DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Latch the item, step the walk pointer and capture the fetched entry
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= in_item.action;
			pos_q <= in_item.position;
			val_q <= in_item.value_in;
			if (in_item.action == iira_pkg::ACT_INSERT) begin
				ptr_q <= cnt_q;
			end else begin
				ptr_q <= iira_pkg::CNT_W'(in_item.position);
			end
		end else begin
			case (cw.ptr_op)
				iira_pkg::K_INC: ptr_q <= ptr_q + iira_pkg::CNT_W'(1);
				iira_pkg::K_DEC: ptr_q <= ptr_q - iira_pkg::CNT_W'(1);
				default:         ptr_q <= ptr_q;
			endcase
		end
		if (cw.take) begin
			data_q <= rd_data;
		end
	end

	// Track the number of entries held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cw.cnt_op)
				iira_pkg::K_INC: cnt_q <= cnt_q + iira_pkg::CNT_W'(1);
				iira_pkg::K_DEC: cnt_q <= cnt_q - iira_pkg::CNT_W'(1);
				default:         cnt_q <= cnt_q;
			endcase
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.emit && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.emit && !out_busy) begin
			out_q.value_out <= cw.val_data ? data_q : '0;
			out_q.status    <= cw.status;
			out_q.count     <= 9'(cnt_q);
		end
	end

endmodule
